// File: sv/espd_pkg.sv
// shared types, widths and register codes of the encoder speed pid controller
package espd_pkg;

   localparam int CountWidthDef   = 16;
   localparam int PwmFullScaleDef = 1000;

   localparam int EncWidth      = 16;
   localparam int GainWidth     = 16;
   localparam int GainCntWidth  = $clog2(GainWidth);
   localparam int TargetWidth   = 16;
   localparam int LimitWidth    = 24;
   localparam int OutLimitWidth = 16;
   localparam int SpeedWidth    = 19;
   localparam int ErrWidth      = 20;
   localparam int DerrWidth     = 21;
   localparam int SumWidth      = 26;
   localparam int DriveWidth    = 17;
   localparam int PwmWidth      = 10;
   localparam int RoundShift    = 8;
   localparam int RoundHalf     = 128;
   localparam int SpeedMaxVal   = 262143;
   localparam int SpeedMinMag   = 262144;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 24;

   localparam logic [CsrIndexWidth-1:0] REG_TARGET_SPEED   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_GAIN_P         = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_GAIN_I         = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_GAIN_D         = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_INTEGRAL_LIMIT = 3'd4;
   localparam logic [CsrIndexWidth-1:0] REG_OUTPUT_LIMIT   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] REG_SPEED_SCALE    = 3'd6;

   localparam logic [GainWidth-1:0]     GAIN_P_RST         = 16'd256;
   localparam logic [GainWidth-1:0]     GAIN_I_RST         = 16'd26;
   localparam logic [GainWidth-1:0]     GAIN_D_RST         = 16'd13;
   localparam logic [LimitWidth-1:0]    INTEGRAL_LIMIT_RST = 24'd100;
   localparam logic [OutLimitWidth-1:0] OUTPUT_LIMIT_RST   = 16'd1000;
   localparam logic [GainWidth-1:0]     SPEED_SCALE_RST    = 16'd1036;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_ABS,
      ST_RND,
      ST_ERR,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_SPEED,
      PH_P,
      PH_I,
      PH_D
   } phase_type;

endpackage

// File: sv/encoder_speed_pid_motor_drive.sv
// encoder speed measurement and pid drive controller with anti-windup, one motor
//
// Each transaction on req_ carries one encoder count sample and yields exactly one
// transaction on rsp_ with the measured speed, the clamped drive, its direction and
// the pwm duty. The block works on one sample at a time and accepts the next one only
// after the previous result has moved to the output register; a result that is not
// yet taken stalls the block in its output state. The time is set by four 16-step
// passes through a single shared bit-serial multiplier (speed scaling, then the p, i
// and d products), each pass shifting in one gain bit per cycle, plus the rounding,
// clamping and error bookkeeping states. The next sample is accepted while a
// finished result still waits in the output register. Registers on csr_ are always
// ready and should only change while no sample is in flight.
module encoder_speed_pid_motor_drive
   import espd_pkg::*;
#(
   parameter int COUNT_WIDTH    = CountWidthDef,
   parameter int PWM_FULL_SCALE = PwmFullScaleDef
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [EncWidth-1:0]        req_encoder_count,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SpeedWidth-1:0] rsp_measured_speed,
   output logic signed [DriveWidth-1:0] rsp_drive,
   output logic                       rsp_reverse,
   output logic [PwmWidth-1:0]        rsp_pwm_duty,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CsrIndexWidth-1:0]   csr_index,
   input  logic [CsrDataWidth-1:0]    csr_data
);

   localparam int MW   = (COUNT_WIDTH > SumWidth) ? COUNT_WIDTH : SumWidth;
   localparam int PW   = MW + GainWidth;
   localparam int AW   = PW + 2;
   localparam int RW   = AW + 1 - RoundShift;
   localparam int CW32 = 32;
   localparam logic [DriveWidth-1:0] FULL_SCALE = DriveWidth'(PWM_FULL_SCALE);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic signed [TargetWidth-1:0]   target_ff, target_in;
   logic [GainWidth-1:0]            gain_p_ff, gain_p_in;
   logic [GainWidth-1:0]            gain_i_ff, gain_i_in;
   logic [GainWidth-1:0]            gain_d_ff, gain_d_in;
   logic [LimitWidth-1:0]           int_limit_ff, int_limit_in;
   logic [OutLimitWidth-1:0]        out_limit_ff, out_limit_in;
   logic [GainWidth-1:0]            scale_ff, scale_in;

   logic [COUNT_WIDTH-1:0]          last_count_ff, last_count_in;
   logic signed [SumWidth-1:0]      error_sum_ff, error_sum_in;
   logic signed [ErrWidth-1:0]      last_error_ff, last_error_in;

   logic signed [MW-1:0]            mcand_ff, mcand_in;
   logic [GainWidth-1:0]            mplier_ff, mplier_in;
   logic signed [MW-1:0]            hi_ff, hi_in;
   logic [GainWidth-1:0]            lo_ff, lo_in;
   logic [GainCntWidth-1:0]         bit_cnt_ff, bit_cnt_in;
   logic signed [AW-1:0]            acc_ff, acc_in;
   logic [AW-1:0]                   mag_ff, mag_in;
   logic                            neg_ff, neg_in;
   logic signed [SpeedWidth-1:0]    speed_ff, speed_in;
   logic signed [ErrWidth-1:0]      err_ff, err_in;
   logic signed [DerrWidth-1:0]     derr_ff, derr_in;
   logic signed [DriveWidth-1:0]    drive_ff, drive_in;
   logic                            reverse_ff, reverse_in;
   logic [PwmWidth-1:0]             pwm_ff, pwm_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SpeedWidth-1:0]    rsp_speed_ff, rsp_speed_in;
   logic signed [DriveWidth-1:0]    rsp_drive_ff, rsp_drive_in;
   logic                            rsp_reverse_ff, rsp_reverse_in;
   logic [PwmWidth-1:0]             rsp_pwm_ff, rsp_pwm_in;

   logic [CW32-1:0]                 cnt_wide;
   logic [COUNT_WIDTH-1:0]          cnt;
   logic signed [COUNT_WIDTH-1:0]   diff;
   logic signed [MW:0]              mul_sum;
   logic signed [PW-1:0]            product;
   logic signed [AW-1:0]            abs_src;
   logic [AW:0]                     rnd_sum;
   logic [RW-1:0]                   rnd;
   logic signed [SumWidth:0]        sum_raw;
   logic signed [SumWidth:0]        lim_pos;
   logic signed [SumWidth:0]        lim_neg;
   logic [OutLimitWidth-1:0]        clip;
   logic [DriveWidth-1:0]           clip_ext;

   assign cnt_wide = CW32'(req_encoder_count);
   assign cnt      = cnt_wide[COUNT_WIDTH-1:0];
   assign diff     = cnt - last_count_ff;

   // shift-add step, one gain bit per cycle
   assign mul_sum  = {hi_ff[MW-1], hi_ff}
                   + (mplier_ff[0] ? {mcand_ff[MW-1], mcand_ff} : {(MW + 1){1'b0}});
   assign product  = {hi_ff, lo_ff};

   assign abs_src  = (phase_ff == PH_SPEED) ? AW'(product) : acc_ff;
   assign rnd_sum  = {1'b0, mag_ff} + (AW + 1)'(RoundHalf);
   assign rnd      = rnd_sum[AW:RoundShift];

   assign sum_raw  = (SumWidth + 1)'(error_sum_ff) + (SumWidth + 1)'(err_ff);
   assign lim_pos  = (SumWidth + 1)'({1'b0, int_limit_ff});
   assign lim_neg  = -lim_pos;

   assign clip     = (rnd > RW'(out_limit_ff)) ? out_limit_ff : rnd[OutLimitWidth-1:0];
   assign clip_ext = DriveWidth'(clip);

   assign req_ready          = (state_ff == ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_measured_speed = rsp_speed_ff;
   assign rsp_drive          = rsp_drive_ff;
   assign rsp_reverse        = rsp_reverse_ff;
   assign rsp_pwm_duty       = rsp_pwm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_SPEED;
         target_ff     <= '0;
         gain_p_ff     <= GAIN_P_RST;
         gain_i_ff     <= GAIN_I_RST;
         gain_d_ff     <= GAIN_D_RST;
         int_limit_ff  <= INTEGRAL_LIMIT_RST;
         out_limit_ff  <= OUTPUT_LIMIT_RST;
         scale_ff      <= SPEED_SCALE_RST;
         last_count_ff <= '0;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
         bit_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         target_ff     <= target_in;
         gain_p_ff     <= gain_p_in;
         gain_i_ff     <= gain_i_in;
         gain_d_ff     <= gain_d_in;
         int_limit_ff  <= int_limit_in;
         out_limit_ff  <= out_limit_in;
         scale_ff      <= scale_in;
         last_count_ff <= last_count_in;
         error_sum_ff  <= error_sum_in;
         last_error_ff <= last_error_in;
         bit_cnt_ff    <= bit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mcand_ff       <= mcand_in;
      mplier_ff      <= mplier_in;
      hi_ff          <= hi_in;
      lo_ff          <= lo_in;
      acc_ff         <= acc_in;
      mag_ff         <= mag_in;
      neg_ff         <= neg_in;
      speed_ff       <= speed_in;
      err_ff         <= err_in;
      derr_ff        <= derr_in;
      drive_ff       <= drive_in;
      reverse_ff     <= reverse_in;
      pwm_ff         <= pwm_in;
      rsp_speed_ff   <= rsp_speed_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_reverse_ff <= rsp_reverse_in;
      rsp_pwm_ff     <= rsp_pwm_in;
   end

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      target_in      = target_ff;
      gain_p_in      = gain_p_ff;
      gain_i_in      = gain_i_ff;
      gain_d_in      = gain_d_ff;
      int_limit_in   = int_limit_ff;
      out_limit_in   = out_limit_ff;
      scale_in       = scale_ff;
      last_count_in  = last_count_ff;
      error_sum_in   = error_sum_ff;
      last_error_in  = last_error_ff;
      mcand_in       = mcand_ff;
      mplier_in      = mplier_ff;
      hi_in          = hi_ff;
      lo_in          = lo_ff;
      bit_cnt_in     = bit_cnt_ff;
      acc_in         = acc_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      speed_in       = speed_ff;
      err_in         = err_ff;
      derr_in        = derr_ff;
      drive_in       = drive_ff;
      reverse_in     = reverse_ff;
      pwm_in         = pwm_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_speed_in   = rsp_speed_ff;
      rsp_drive_in   = rsp_drive_ff;
      rsp_reverse_in = rsp_reverse_ff;
      rsp_pwm_in     = rsp_pwm_ff;

      if (csr_valid) begin
         unique case (csr_index)
            REG_TARGET_SPEED:   target_in    = csr_data[TargetWidth-1:0];
            REG_GAIN_P:         gain_p_in    = csr_data[GainWidth-1:0];
            REG_GAIN_I:         gain_i_in    = csr_data[GainWidth-1:0];
            REG_GAIN_D:         gain_d_in    = csr_data[GainWidth-1:0];
            REG_INTEGRAL_LIMIT: int_limit_in = csr_data[LimitWidth-1:0];
            REG_OUTPUT_LIMIT:   out_limit_in = csr_data[OutLimitWidth-1:0];
            REG_SPEED_SCALE:    scale_in     = csr_data[GainWidth-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_count_in = cnt;
               mcand_in      = MW'(diff);
               mplier_in     = scale_ff;
               hi_in         = '0;
               bit_cnt_in    = '0;
               phase_in      = PH_SPEED;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            hi_in      = mul_sum[MW:1];
            lo_in      = {mul_sum[0], lo_ff[GainWidth-1:1]};
            mplier_in  = mplier_ff >> 1;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == GainCntWidth'(GainWidth - 1)) begin
               state_in = (phase_ff == PH_SPEED) ? ST_ABS : ST_ADD;
            end
         end
         ST_ADD: begin
            acc_in     = acc_ff + AW'(product);
            hi_in      = '0;
            bit_cnt_in = '0;
            case (phase_ff)
               PH_P: begin
                  mcand_in  = MW'(error_sum_ff);
                  mplier_in = gain_i_ff;
                  phase_in  = PH_I;
                  state_in  = ST_MUL;
               end
               PH_I: begin
                  mcand_in  = MW'(derr_ff);
                  mplier_in = gain_d_ff;
                  phase_in  = PH_D;
                  state_in  = ST_MUL;
               end
               default: begin
                  state_in = ST_ABS;
               end
            endcase
         end
         ST_ABS: begin
            neg_in   = abs_src[AW-1];
            mag_in   = abs_src[AW-1] ? AW'(-abs_src) : AW'(abs_src);
            state_in = ST_RND;
         end
         ST_RND: begin
            if (phase_ff == PH_SPEED) begin
               if (neg_ff) begin
                  speed_in = (rnd >= RW'(SpeedMinMag)) ? SpeedWidth'(-SpeedMinMag)
                                                       : -rnd[SpeedWidth-1:0];
               end else begin
                  speed_in = (rnd > RW'(SpeedMaxVal)) ? SpeedWidth'(SpeedMaxVal)
                                                      : rnd[SpeedWidth-1:0];
               end
               state_in = ST_ERR;
            end else begin
               drive_in   = neg_ff ? -clip_ext : clip_ext;
               reverse_in = neg_ff && (clip != '0);
               pwm_in     = (clip_ext > FULL_SCALE) ? FULL_SCALE[PwmWidth-1:0]
                                                    : clip_ext[PwmWidth-1:0];
               state_in   = ST_OUT;
            end
         end
         ST_ERR: begin
            err_in   = ErrWidth'(target_ff) - ErrWidth'(speed_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (sum_raw > lim_pos) begin
               error_sum_in = lim_pos[SumWidth-1:0];
            end else if (sum_raw < lim_neg) begin
               error_sum_in = lim_neg[SumWidth-1:0];
            end else begin
               error_sum_in = sum_raw[SumWidth-1:0];
            end
            derr_in       = DerrWidth'(err_ff) - DerrWidth'(last_error_ff);
            last_error_in = err_ff;
            acc_in        = '0;
            mcand_in      = MW'(err_ff);
            mplier_in     = gain_p_ff;
            hi_in         = '0;
            bit_cnt_in    = '0;
            phase_in      = PH_P;
            state_in      = ST_MUL;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_speed_in   = speed_ff;
               rsp_drive_in   = drive_ff;
               rsp_reverse_in = reverse_ff;
               rsp_pwm_in     = pwm_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: sv/espd_checker.sv
// port-level assertions for the encoder speed pid controller, bound to the top level
module espd_checker
   import espd_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [DriveWidth-1:0] rsp_drive,
   input logic                         rsp_reverse,
   input logic [PwmWidth-1:0]          rsp_pwm_duty
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // one sample in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while busy");

   // direction bit follows the sign of the drive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reverse == rsp_drive[DriveWidth-1]))
      else $error("reverse does not match drive sign");

   // zero drive gives zero duty
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_drive == '0)) |-> (rsp_pwm_duty == '0))
      else $error("nonzero duty with zero drive");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_drive)))
      else $error("stalled result changed");

endmodule

bind encoder_speed_pid_motor_drive espd_checker u_espd_checker (.*);
